/* hdl/bcds_pkg.sv */
// Shared types and constants of the bilinear crop downscaler.
package bcds_pkg;

   localparam int CHAN_W     = 8;
   localparam int SRC_COL_W  = 9;
   localparam int SRC_ROW_W  = 8;
   localparam int ICON_IDX_W = 6;
   localparam int SRC_W_REG_W = 10;
   localparam int SRC_H_REG_W = 9;
   localparam int CSR_DATA_W = 10;
   localparam int FRAC_W     = 9;

   localparam logic [SRC_W_REG_W-1:0] SOURCE_WIDTH_RESET  = 10'd48;
   localparam logic [SRC_H_REG_W-1:0] SOURCE_HEIGHT_RESET = 9'd36;

   // neighbor order inside one fetched 2x2 window
   localparam int PIX_00 = 0;
   localparam int PIX_10 = 1;
   localparam int PIX_01 = 2;
   localparam int PIX_11 = 3;

   typedef enum logic [0:0] {
      OP_WRITE   = 1'b0,
      OP_REQUEST = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_SOURCE_WIDTH  = 1'b0,
      CSR_SOURCE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [CHAN_W-1:0] chan_type;
   // element 0 red, 1 green, 2 blue, 3 alpha
   typedef chan_type [3:0] rgba_type;

endpackage

/* hdl/bcds_if.sv */
// Request and response channel interfaces of the bilinear crop downscaler.
interface bcds_req_if import bcds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   opcode_type            opcode;
   logic [SRC_COL_W-1:0]  src_col;
   logic [SRC_ROW_W-1:0]  src_row;
   logic [ICON_IDX_W-1:0] icon_col;
   logic [ICON_IDX_W-1:0] icon_row;
   chan_type              in_red;
   chan_type              in_green;
   chan_type              in_blue;
   chan_type              in_alpha;

   modport source (
      output valid, opcode, src_col, src_row, icon_col, icon_row,
             in_red, in_green, in_blue, in_alpha,
      input  ready
   );
   modport sink (
      input  valid, opcode, src_col, src_row, icon_col, icon_row,
             in_red, in_green, in_blue, in_alpha,
      output ready
   );
endinterface

interface bcds_rsp_if import bcds_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type icon_red;
   chan_type icon_green;
   chan_type icon_blue;
   chan_type icon_alpha;

   modport source (
      output valid, icon_red, icon_green, icon_blue, icon_alpha,
      input  ready
   );
   modport sink (
      input  valid, icon_red, icon_green, icon_blue, icon_alpha,
      output ready
   );
endinterface

/* hdl/bcds_ram.sv */
// Generic single-port RAM with registered read data.
module bcds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                         wdata,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rd_data_ff <= mem[addr];
   end

   assign rdata = rd_data_ff;
endmodule

/* hdl/bcds_geom.sv */
// Crop geometry sequencer: clamps the source size and derives the centered crop.
module bcds_geom import bcds_pkg::*; #(
   parameter int OUT_W     = 48,
   parameter int OUT_H     = 36,
   parameter int MAX_SRC_W = 512,
   parameter int MAX_SRC_H = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                restart,
   input  logic [SRC_W_REG_W-1:0]              source_width,
   input  logic [SRC_H_REG_W-1:0]              source_height,
   output logic                                valid,
   output logic [$clog2(MAX_SRC_W+1)-1:0]      w,
   output logic [$clog2(MAX_SRC_H+1)-1:0]      h,
   output logic [$clog2(MAX_SRC_W+1)-1:0]      cx,
   output logic [$clog2(MAX_SRC_W+1)-1:0]      cw,
   output logic [$clog2(MAX_SRC_H+1)-1:0]      cy,
   output logic [$clog2(MAX_SRC_H+1)-1:0]      ch
);
   localparam int W_W    = $clog2(MAX_SRC_W + 1);
   localparam int H_W    = $clog2(MAX_SRC_H + 1);
   localparam int PROD_A = MAX_SRC_H * OUT_W;
   localparam int PROD_B = MAX_SRC_W * OUT_H;
   localparam int DV_W   = $clog2((PROD_A > PROD_B ? PROD_A : PROD_B) + 1) + 1;
   localparam int DR_W   = $clog2((OUT_W > OUT_H ? OUT_W : OUT_H) + 1);
   // reciprocals scaled by 2^DV_W; the quotient estimate is low by at most one
   localparam logic [DV_W:0] RCP_H = (DV_W+1)'((1 << DV_W) / OUT_H);
   localparam logic [DV_W:0] RCP_W = (DV_W+1)'((1 << DV_W) / OUT_W);

   typedef enum logic [5:0] {
      G_PREP  = 6'b000001,
      G_CMP   = 6'b000010,
      G_DIV   = 6'b000100,
      G_FIX   = 6'b001000,
      G_DONE  = 6'b010000,
      G_READY = 6'b100000
   } geom_state_type;

   geom_state_type    state_ff, state_in;
   logic [W_W-1:0]    w_ff, w_in, cx_ff, cx_in, cw_ff, cw_in;
   logic [H_W-1:0]    h_ff, h_in, cy_ff, cy_in, ch_ff, ch_in;
   logic              wide_ff, wide_in, tall_ff, tall_in;
   logic [DV_W-1:0]   dvd_ff, dvd_in, quo_ff, quo_in;
   logic [DR_W-1:0]   div_ff, div_in;
   logic [DV_W:0]     rcp_ff, rcp_in;
   logic [DV_W-1:0]   lhs, rhs;
   logic [2*DV_W:0]   prod;
   logic [DV_W-1:0]   rmd;

   assign lhs  = DV_W'(w_ff) * DV_W'(OUT_H);
   assign rhs  = DV_W'(OUT_W) * DV_W'(h_ff);
   assign prod = (2*DV_W+1)'(dvd_ff) * (2*DV_W+1)'(rcp_ff);
   assign rmd  = dvd_ff - quo_ff * DV_W'(div_ff);

   always_comb begin
      state_in = state_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      cx_in    = cx_ff;
      cw_in    = cw_ff;
      cy_in    = cy_ff;
      ch_in    = ch_ff;
      wide_in  = wide_ff;
      tall_in  = tall_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      rcp_in   = rcp_ff;
      unique case (state_ff)
         G_PREP: begin
            if (source_width == '0) begin
               w_in = W_W'(1);
            end else if (32'(source_width) > 32'(MAX_SRC_W)) begin
               w_in = W_W'(MAX_SRC_W);
            end else begin
               w_in = W_W'(source_width);
            end
            if (source_height == '0) begin
               h_in = H_W'(1);
            end else if (32'(source_height) > 32'(MAX_SRC_H)) begin
               h_in = H_W'(MAX_SRC_H);
            end else begin
               h_in = H_W'(source_height);
            end
            state_in = G_CMP;
         end
         G_CMP: begin
            wide_in = lhs > rhs;
            tall_in = lhs < rhs;
            if (lhs > rhs) begin
               dvd_in = DV_W'(h_ff) * DV_W'(OUT_W);
               div_in = DR_W'(OUT_H);
               rcp_in = RCP_H;
            end else begin
               dvd_in = DV_W'(w_ff) * DV_W'(OUT_H);
               div_in = DR_W'(OUT_W);
               rcp_in = RCP_W;
            end
            state_in = (lhs == rhs) ? G_DONE : G_DIV;
         end
         G_DIV: begin
            // quotient estimate by reciprocal multiplication
            quo_in   = prod[2*DV_W-1:DV_W];
            state_in = G_FIX;
         end
         G_FIX: begin
            // bump the estimate when the remainder still holds a divisor
            quo_in   = quo_ff + DV_W'(rmd >= DV_W'(div_ff));
            state_in = G_DONE;
         end
         G_DONE: begin
            cx_in = '0;
            cw_in = w_ff;
            cy_in = '0;
            ch_in = h_ff;
            if (wide_ff) begin
               cw_in = W_W'(quo_ff);
               cx_in = (w_ff - W_W'(quo_ff)) >> 1;
            end else if (tall_ff) begin
               ch_in = H_W'(quo_ff);
               cy_in = (h_ff - H_W'(quo_ff)) >> 1;
            end
            state_in = G_READY;
         end
         G_READY: begin
            state_in = G_READY;
         end
         default: begin
            state_in = G_PREP;
         end
      endcase
      if (restart) begin
         state_in = G_PREP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_PREP;
      end else begin
         state_ff <= state_in;
      end
      w_ff    <= w_in;
      h_ff    <= h_in;
      cx_ff   <= cx_in;
      cw_ff   <= cw_in;
      cy_ff   <= cy_in;
      ch_ff   <= ch_in;
      wide_ff <= wide_in;
      tall_ff <= tall_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      rcp_ff  <= rcp_in;
   end

   assign valid = state_ff == G_READY;
   assign w     = w_ff;
   assign h     = h_ff;
   assign cx    = cx_ff;
   assign cw    = cw_ff;
   assign cy    = cy_ff;
   assign ch    = ch_ff;
endmodule

/* hdl/bcds_loc.sv */
// Four-stage sample locator for one axis: position, neighbors and fraction.
module bcds_loc import bcds_pkg::*; #(
   parameter int OUT_N = 48,
   parameter int MAX_S = 512
) (
   input  logic                                   clock,
   input  logic [ICON_IDX_W-1:0]                  idx,
   input  logic [$clog2(MAX_S+1)-1:0]             crop_off,
   input  logic [$clog2(MAX_S+1)-1:0]             crop_n,
   input  logic [$clog2(MAX_S+1)-1:0]             size,
   output logic [(MAX_S > 1 ? $clog2(MAX_S) : 1)-1:0] n0,
   output logic [(MAX_S > 1 ? $clog2(MAX_S) : 1)-1:0] n1,
   output logic [FRAC_W-1:0]                      frac
);
   localparam int S_W     = $clog2(MAX_S + 1);
   localparam int I_W     = MAX_S > 1 ? $clog2(MAX_S) : 1;
   localparam int IDX_MAX = (1 << ICON_IDX_W) - 1;
   localparam int NUM_MAX = 2 * OUT_N * MAX_S + (2 * IDX_MAX + 1) * MAX_S;
   localparam int NUM_W   = $clog2(NUM_MAX + 1);
   localparam int X_W     = NUM_W + 8;
   localparam int D       = 2 * OUT_N;
   localparam logic [63:0] RECIP = (64'd1 << X_W) / 64'(D);

   logic [NUM_W-1:0]   full, mag_s1, ip, size_m1, n0_wide, n1_wide;
   logic               neg_s1, neg_s2, neg_s3;
   logic [X_W-1:0]     x_s1, x_s2, q_s2, r, pos_s3;
   logic [2*X_W-1:0]   prod;
   logic [I_W-1:0]     n0_ff, n1_ff;
   logic [FRAC_W-1:0]  frac_ff, frac_in;

   // stage 1: numerator of the position in units of 1/(2*OUT_N)
   assign full = NUM_W'(crop_off) * NUM_W'(D) + NUM_W'({idx, 1'b1}) * NUM_W'(crop_n);

   always_ff @(posedge clock) begin
      neg_s1 <= full < NUM_W'(OUT_N);
      mag_s1 <= full - NUM_W'(OUT_N);
   end

   // stage 2: quotient estimate by reciprocal, low by at most one
   assign x_s1 = {mag_s1, 8'd0};
   assign prod = (2*X_W)'(x_s1) * (2*X_W)'(RECIP[X_W-1:0]);

   always_ff @(posedge clock) begin
      neg_s2 <= neg_s1;
      x_s2   <= x_s1;
      q_s2   <= prod[2*X_W-1:X_W];
   end

   // stage 3: correct the estimate
   assign r = x_s2 - q_s2 * X_W'(D);

   always_ff @(posedge clock) begin
      neg_s3 <= neg_s2;
      pos_s3 <= q_s2 + X_W'(r >= X_W'(D));
   end

   // stage 4: clamp to the image
   assign ip      = pos_s3[X_W-1:8];
   assign size_m1 = NUM_W'(size) - NUM_W'(1);

   always_comb begin
      if (neg_s3) begin
         n0_wide = '0;
         frac_in = '0;
      end else if (ip > size_m1) begin
         n0_wide = size_m1;
         frac_in = FRAC_W'(256);
      end else begin
         n0_wide = ip;
         frac_in = FRAC_W'(pos_s3[7:0]);
      end
      n1_wide = (n0_wide + NUM_W'(1) > size_m1) ? size_m1 : n0_wide + NUM_W'(1);
   end

   always_ff @(posedge clock) begin
      n0_ff   <= I_W'(n0_wide);
      n1_ff   <= I_W'(n1_wide);
      frac_ff <= frac_in;
   end

   assign n0   = n0_ff;
   assign n1   = n1_ff;
   assign frac = frac_ff;
endmodule

/* hdl/bcds_blend.sv */
// Two-stage bilinear blend of a 2x2 RGBA window with rounding and saturation.
module bcds_blend import bcds_pkg::*; (
   input  logic              clock,
   input  rgba_type          pix [4],
   input  logic [FRAC_W-1:0] fx,
   input  logic [FRAC_W-1:0] fy,
   output rgba_type          result
);
   logic [15:0]       top_ff [4];
   logic [15:0]       bot_ff [4];
   logic [FRAC_W-1:0] fy_ff;
   logic [FRAC_W-1:0] wx0, wy0;
   logic [24:0]       acc [4];
   logic [8:0]        rounded [4];

   assign wx0 = FRAC_W'(256) - fx;
   assign wy0 = FRAC_W'(256) - fy_ff;

   // horizontal pass, one lane per channel
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         top_ff[k] <= 16'(17'(pix[PIX_00][k]) * 17'(wx0) + 17'(pix[PIX_10][k]) * 17'(fx));
         bot_ff[k] <= 16'(17'(pix[PIX_01][k]) * 17'(wx0) + 17'(pix[PIX_11][k]) * 17'(fx));
      end
      fy_ff <= fy;
   end

   // vertical pass, round half up, saturate
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         acc[k]     = 25'(top_ff[k]) * 25'(wy0) + 25'(bot_ff[k]) * 25'(fy_ff)
                      + 25'd32768;
         rounded[k] = acc[k][24:16];
         result[k]  = rounded[k][8] ? chan_type'(8'hFF) : rounded[k][7:0];
      end
   end
endmodule

/* hdl/bilinear_crop_downscaler_unit.sv */
// Top level of the bilinear center-crop downscaler.
//
// Usage:
//   req_ch carries pixel writes (opcode OP_WRITE) into the frame store and
//   icon pixel requests (opcode OP_REQUEST). A transfer happens on a rising
//   edge with valid and ready high. rsp_ch carries one RGBA result per
//   request and nothing for a write.
//   After a write the next transfer can follow right away.
//   A request passes through the sample locator pipeline, four reads of the
//   2x2 window from the single-port frame store, a drain step for the last
//   read data, the horizontal blend and the load of the response register;
//   only then can the next transfer follow.
//   The response register holds a finished result while the receiver
//   stalls; the block takes new writes and a new request meanwhile and
//   waits only when a second result is ready before the first is taken.
//   Reset restores source_width 48 and source_height 36 and recomputes the
//   crop geometry; ready stays low until it is done. Every csr write starts
//   the same recomputation. The frame store is not cleared: read only
//   written pixels.
module bilinear_crop_downscaler_unit import bcds_pkg::*; #(
   parameter int OUT_W     = 48,
   parameter int OUT_H     = 36,
   parameter int MAX_SRC_W = 512,
   parameter int MAX_SRC_H = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   bcds_req_if.sink              req_ch,
   bcds_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   localparam int W_W   = $clog2(MAX_SRC_W + 1);
   localparam int H_W   = $clog2(MAX_SRC_H + 1);
   localparam int XI_W  = MAX_SRC_W > 1 ? $clog2(MAX_SRC_W) : 1;
   localparam int YI_W  = MAX_SRC_H > 1 ? $clog2(MAX_SRC_H) : 1;
   localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
   localparam int A_W   = DEPTH > 1 ? $clog2(DEPTH) : 1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOCATE = 6'b000010,
      ST_READ   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_BLEND  = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic [SRC_W_REG_W-1:0]  src_width_ff;
   logic [SRC_H_REG_W-1:0]  src_height_ff;
   logic [ICON_IDX_W-1:0]   icon_col_ff, icon_row_ff;
   logic                    rd_pend_ff;
   logic [1:0]              rd_sel_ff;
   rgba_type                pix_ff [4];
   logic                    rsp_valid_ff, rsp_valid_in;
   rgba_type                rsp_data_ff;

   logic                    req_accept, rsp_load, geo_valid;
   logic [W_W-1:0]          geo_w, geo_cx, geo_cw;
   logic [H_W-1:0]          geo_h, geo_cy, geo_ch;
   logic [XI_W-1:0]         x0, x1, x_sel;
   logic [YI_W-1:0]         y0, y1, y_sel;
   logic [FRAC_W-1:0]       fx, fy;
   logic                    wr_in_range, mem_we;
   logic [A_W-1:0]          mem_addr, wr_addr, rd_addr;
   rgba_type                mem_wdata, mem_rdata, blend_out;

   assign req_ch.ready = (state_ff == ST_IDLE) && geo_valid;
   assign req_accept   = req_ch.valid && req_ch.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SOURCE_WIDTH_RESET;
         src_height_ff <= SOURCE_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  src_width_ff  <= csr_wr_data[SRC_W_REG_W-1:0];
            CSR_SOURCE_HEIGHT: src_height_ff <= csr_wr_data[SRC_H_REG_W-1:0];
            default: ;
         endcase
      end
   end

   bcds_geom #(
      .OUT_W     (OUT_W),
      .OUT_H     (OUT_H),
      .MAX_SRC_W (MAX_SRC_W),
      .MAX_SRC_H (MAX_SRC_H)
   ) u_geom (
      .clock         (clock),
      .reset         (reset),
      .restart       (csr_wr_en),
      .source_width  (src_width_ff),
      .source_height (src_height_ff),
      .valid         (geo_valid),
      .w             (geo_w),
      .h             (geo_h),
      .cx            (geo_cx),
      .cw            (geo_cw),
      .cy            (geo_cy),
      .ch            (geo_ch)
   );

   // hold the requested icon position for the whole request
   always_ff @(posedge clock) begin
      if (req_accept && req_ch.opcode == OP_REQUEST) begin
         icon_col_ff <= req_ch.icon_col;
         icon_row_ff <= req_ch.icon_row;
      end
   end

   bcds_loc #(.OUT_N(OUT_W), .MAX_S(MAX_SRC_W)) u_loc_x (
      .clock    (clock),
      .idx      (icon_col_ff),
      .crop_off (geo_cx),
      .crop_n   (geo_cw),
      .size     (geo_w),
      .n0       (x0),
      .n1       (x1),
      .frac     (fx)
   );

   bcds_loc #(.OUT_N(OUT_H), .MAX_S(MAX_SRC_H)) u_loc_y (
      .clock    (clock),
      .idx      (icon_row_ff),
      .crop_off (geo_cy),
      .crop_n   (geo_ch),
      .size     (geo_h),
      .n0       (y0),
      .n1       (y1),
      .frac     (fy)
   );

   // frame store port: writes in idle, window reads in ST_READ
   assign wr_in_range = (32'(req_ch.src_col) < 32'(MAX_SRC_W))
                     && (32'(req_ch.src_row) < 32'(MAX_SRC_H));
   assign mem_we      = req_accept && req_ch.opcode == OP_WRITE && wr_in_range;
   assign wr_addr     = A_W'(32'(req_ch.src_row) * 32'(MAX_SRC_W) + 32'(req_ch.src_col));
   assign x_sel       = cnt_ff[0] ? x1 : x0;
   assign y_sel       = cnt_ff[1] ? y1 : y0;
   assign rd_addr     = A_W'(32'(y_sel) * 32'(MAX_SRC_W) + 32'(x_sel));
   assign mem_addr    = mem_we ? wr_addr : rd_addr;
   assign mem_wdata   = {req_ch.in_alpha, req_ch.in_blue, req_ch.in_green, req_ch.in_red};

   bcds_ram #(.WIDTH($bits(rgba_type)), .DEPTH(DEPTH)) u_frame_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // capture read data in the cycle after each read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= state_ff == ST_READ;
      end
      rd_sel_ff <= cnt_ff;
      if (rd_pend_ff) begin
         pix_ff[rd_sel_ff] <= mem_rdata;
      end
   end

   bcds_blend u_blend (
      .clock  (clock),
      .pix    (pix_ff),
      .fx     (fx),
      .fy     (fy),
      .result (blend_out)
   );

   // request sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_accept && req_ch.opcode == OP_REQUEST) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // response register: load when empty or being drained this cycle
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= blend_out;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.icon_red   = rsp_data_ff[0];
   assign rsp_ch.icon_green = rsp_data_ff[1];
   assign rsp_ch.icon_blue  = rsp_data_ff[2];
   assign rsp_ch.icon_alpha = rsp_data_ff[3];

   // frame store is never written while a window fetch is in flight
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !mem_we)
      else $error("frame store written during a request");

   // read data is captured only right after window reads
   a_capture_window: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_READ || state_ff == ST_DRAIN))
      else $error("read data captured outside a window fetch");

   // a register write invalidates the crop geometry
   a_csr_restarts_geom: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !geo_valid)
      else $error("crop geometry still valid after a register write");

   // window neighbors lie inside the clamped image
   a_window_in_image: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ((W_W'(x1) < geo_w) && (H_W'(y1) < geo_h)
                                 && (x0 <= x1) && (y0 <= y1)))
      else $error("window neighbor outside the source image");
endmodule
